// ===== rtl/core/dnspc_pkg.sv =====
// Shared types and constants for the DNS port packet classifier.
`default_nettype none
package dnspc_pkg;
    localparam logic [15:0] KIND_IP4    = 16'h0800;
    localparam logic [15:0] KIND_IP6    = 16'h86DD;
    localparam logic [15:0] KIND_TAG_Q  = 16'h8100;
    localparam logic [15:0] KIND_TAG_AD = 16'h88A8;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  ETH_HDR_LEN = 8'd14;
    localparam logic [7:0]  TAG_LEN     = 8'd4;
    localparam logic [7:0]  IP4_MIN_LEN = 8'd20;
    localparam logic [7:0]  IP6_LEN     = 8'd40;
    localparam logic [7:0]  UDP_LEN     = 8'd8;
    localparam logic [7:0]  TCP_LEN     = 8'd20;
    localparam logic [3:0]  IHL_MIN     = 4'd5;

    // Query or table write carried down the cell chain.
    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [15:0] src;
        logic [15:0] dst;
        logic        hit;
        logic        wr;
        logic [4:0]  wr_index;
        logic [15:0] wr_port;
        logic        wr_valid;
    } dnspc_query_t;
endpackage
`default_nettype wire

// ===== rtl/core/dnspc_cell.sv =====
// One port table slot: holds an entry and matches the passing query.
`default_nettype none
module dnspc_cell
    import dnspc_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         advance,
    input  dnspc_query_t      q_in,
    output dnspc_query_t      q_out
);
    logic        valid_reg;
    logic [15:0] port_reg;
    logic        wr_hit;
    dnspc_query_t q_reg, q_next;

    // Apply a table write as it passes this slot, in order with the queries.
    assign wr_hit = advance && q_in.wr && (32'(q_in.wr_index) == INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_hit) begin
            valid_reg <= q_in.wr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            port_reg <= q_in.wr_port;
        end
    end

    always_comb begin
        q_next = q_in;
        q_next.hit = q_in.hit | (q_in.ok & valid_reg &
                     (port_reg == q_in.src || port_reg == q_in.dst));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
            q_reg.wr    <= 1'b0;
        end else if (advance) begin
            q_reg.valid <= q_next.valid;
            q_reg.wr    <= q_next.wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            q_reg.ok       <= q_next.ok;
            q_reg.src      <= q_next.src;
            q_reg.dst      <= q_next.dst;
            q_reg.hit      <= q_next.hit;
            q_reg.wr_index <= q_next.wr_index;
            q_reg.wr_port  <= q_next.wr_port;
            q_reg.wr_valid <= q_next.wr_valid;
        end
    end

    assign q_out = q_reg;
endmodule
`default_nettype wire

// ===== rtl/core/dnspc_parser.sv =====
// Byte-serial header parser: tracks one frame and emits a port query at its end.
`default_nettype none
module dnspc_parser
    import dnspc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_en,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_in,
    output dnspc_query_t     query
);
    logic [7:0]  cnt_reg;
    logic [15:0] kind_reg;
    logic        vlan_reg;
    logic [3:0]  ihl_reg;
    logic        frag_reg;
    logic [7:0]  proto_reg;
    logic [15:0] src_reg, dst_reg;

    logic [7:0]  cnt_next;
    logic [15:0] kind_next;
    logic        vlan_next;
    logic [3:0]  ihl_next;
    logic        frag_next;
    logic [7:0]  proto_next;
    logic [15:0] src_next, dst_next;
    logic [7:0]  l3, q, r, len;
    logic [8:0]  t_off, t_end;
    logic        t_ok, done, ok;

    function automatic logic [8:0] toff(input logic [15:0] k, input logic [3:0] ihl,
                                        input logic [7:0] l3v);
        logic [8:0] res;
        res = 9'd0;
        if (k == KIND_IP4) begin
            if (ihl >= IHL_MIN) res = {1'b0, l3v} + {3'b0, ihl, 2'b00};
        end else if (k == KIND_IP6) begin
            res = {1'b0, l3v} + {1'b0, IP6_LEN};
        end
        return res;
    endfunction

    always_comb begin
        cnt_next = cnt_reg; kind_next = kind_reg; vlan_next = vlan_reg;
        ihl_next = ihl_reg; frag_next = frag_reg; proto_next = proto_reg;
        src_next = src_reg; dst_next = dst_reg;
        done = 1'b0;
        l3 = 8'd0; q = 8'd0; r = 8'd0; t_off = 9'd0;
        if (cnt_reg == 8'd12) begin
            kind_next[15:8] = byte_in; done = 1'b1;
        end else if (cnt_reg == 8'd13) begin
            kind_next[7:0] = byte_in; done = 1'b1;
        end else begin
            if (cnt_reg == 8'd14)
                vlan_next = (kind_reg == KIND_TAG_Q) || (kind_reg == KIND_TAG_AD);
            if (vlan_next && cnt_reg == 8'd16) begin
                kind_next[15:8] = byte_in; done = 1'b1;
            end else if (vlan_next && cnt_reg == 8'd17) begin
                kind_next[7:0] = byte_in; done = 1'b1;
            end
        end
        if (!done) begin
            l3 = vlan_next ? (ETH_HDR_LEN + TAG_LEN) : ETH_HDR_LEN;
            if (cnt_reg >= l3) begin
                q = cnt_reg - l3;
                if (kind_next == KIND_IP4) begin
                    if (q == 8'd0) ihl_next = byte_in[3:0];
                    else if (q == 8'd6) frag_next = byte_in[4:0] != 5'd0;
                    else if (q == 8'd7) frag_next = frag_reg | (byte_in != 8'd0);
                    else if (q == 8'd9) proto_next = byte_in;
                end else if (kind_next == KIND_IP6) begin
                    if (q == 8'd6) proto_next = byte_in;
                end
                t_off = toff(kind_next, ihl_next, l3);
                if (t_off != 9'd0 && {1'b0, cnt_reg} >= t_off &&
                    {1'b0, cnt_reg} < t_off + 9'd4) begin
                    r = 8'({1'b0, cnt_reg} - t_off);
                    case (r[1:0])
                        2'd0: src_next[15:8] = byte_in;
                        2'd1: src_next[7:0]  = byte_in;
                        2'd2: dst_next[15:8] = byte_in;
                        default: dst_next[7:0] = byte_in;
                    endcase
                end
            end
        end
        if (cnt_reg != 8'hFF) cnt_next = cnt_reg + 8'd1;
    end

    // Final acceptance check on the updated state.
    logic [8:0] l3e, lim;
    always_comb begin
        len   = cnt_next;
        l3e   = vlan_next ? 9'(ETH_HDR_LEN + TAG_LEN) : 9'(ETH_HDR_LEN);
        t_ok  = 1'b0;
        lim   = 9'd0;
        t_end = toff(kind_next, ihl_next, l3e[7:0]);
        if (kind_next == KIND_IP4)
            t_ok = ({1'b0, len} >= l3e + 9'(IP4_MIN_LEN)) && ihl_next >= IHL_MIN && !frag_next;
        else if (kind_next == KIND_IP6)
            t_ok = {1'b0, len} >= l3e + 9'(IP6_LEN);
        if (proto_next == PROTO_UDP) lim = t_end + 9'(UDP_LEN);
        else if (proto_next == PROTO_TCP) lim = t_end + 9'(TCP_LEN);
        else t_ok = 1'b0;
        ok = t_ok && len >= ETH_HDR_LEN && {1'b0, len} >= lim;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_en && last_in)) begin
            cnt_reg <= 8'd0; kind_reg <= 16'd0; vlan_reg <= 1'b0; ihl_reg <= 4'd0;
            frag_reg <= 1'b0; proto_reg <= 8'd0; src_reg <= 16'd0; dst_reg <= 16'd0;
        end else if (byte_en) begin
            cnt_reg <= cnt_next; kind_reg <= kind_next; vlan_reg <= vlan_next;
            ihl_reg <= ihl_next; frag_reg <= frag_next; proto_reg <= proto_next;
            src_reg <= src_next; dst_reg <= dst_next;
        end
    end

    always_comb begin
        query.valid    = byte_en & last_in;
        query.ok       = ok;
        query.src      = ok ? src_next : 16'd0;
        query.dst      = ok ? dst_next : 16'd0;
        query.hit      = 1'b0;
        query.wr       = 1'b0;
        query.wr_index = 5'd0;
        query.wr_port  = 16'd0;
        query.wr_valid = 1'b0;
    end
endmodule
`default_nettype wire

// ===== rtl/core/dns_port_packet_classifier.sv =====
// Top level: byte parser feeding a chain of port table cells.
// A frame's result word is registered in each of the PORT_TABLE_DEPTH table cells of the
// match chain after its last word is accepted, and is held there while the output stalls.
// Throughput: one word per cycle; the chain advances as a whole whenever its
// tail is empty or the result word is taken.
// Reset: synchronous active-low aresetn clears the parse state, all table
// slots to invalid and all query valid flags.
`default_nettype none
module dns_port_packet_classifier
    import dnspc_pkg::*;
#(
    parameter int unsigned PORT_TABLE_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_packet_byte,
    input  wire logic        s_last_byte,
    input  wire logic [4:0]  s_entry_index,
    input  wire logic [15:0] s_entry_port,
    input  wire logic        s_entry_valid,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_keep_packet,
    output logic             m_headers_ok,
    output logic [15:0]      m_src_port,
    output logic [15:0]      m_dst_port
);
    dnspc_query_t chain [PORT_TABLE_DEPTH+1];
    dnspc_query_t parsed, head;
    logic advance, accept, wr_en;

    // Advance the whole chain unless the tail word is stalled at the output.
    assign advance = !chain[PORT_TABLE_DEPTH].valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;
    // Table writes travel down the chain behind earlier queries, so every
    // query sees the table exactly as it stood when its last byte arrived.
    assign wr_en   = accept && s_req_type;

    dnspc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (accept && !s_req_type),
        .byte_in (s_packet_byte),
        .last_in (s_last_byte),
        .query   (parsed)
    );

    // Merge the table write into the word entering the chain.
    always_comb begin
        head          = parsed;
        head.wr       = wr_en;
        head.wr_index = s_entry_index;
        head.wr_port  = s_entry_port;
        head.wr_valid = s_entry_valid;
    end
    assign chain[0] = head;

    for (genvar i = 0; i < PORT_TABLE_DEPTH; i++) begin : g_cell
        dnspc_cell #(.INDEX(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .q_in     (chain[i]),
            .q_out    (chain[i+1])
        );
    end

    assign m_valid       = chain[PORT_TABLE_DEPTH].valid;
    assign m_keep_packet = chain[PORT_TABLE_DEPTH].hit;
    assign m_headers_ok  = chain[PORT_TABLE_DEPTH].ok;
    assign m_src_port    = chain[PORT_TABLE_DEPTH].src;
    assign m_dst_port    = chain[PORT_TABLE_DEPTH].dst;

    // A kept frame always has recognized headers.
    a_keep_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_keep_packet || m_headers_ok))
        else $error("keep without headers");
    // Dropped frames report zero ports.
    a_zero_ports: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_headers_ok) |-> (m_src_port == 16'd0 && m_dst_port == 16'd0))
        else $error("ports nonzero on drop");
    // Input stalls only when the output is stalled.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("spurious input stall");
endmodule
`default_nettype wire

// ===== tb/tb_dns_port_packet_classifier.sv =====
// Self-checking testbench for the DNS port packet classifier.
`default_nettype none
module tb_dns_port_packet_classifier;
    import dnspc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS  = 32;
    localparam int RANDOM_WORDS = 150;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;

    // Word kinds on the input channel.
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    // Frame shapes for the frame builder.
    localparam int TAG_NONE = 0;
    localparam int TAG_Q    = 1;
    localparam int TAG_AD   = 2;

    typedef struct {
        logic        keep;
        logic        ok;
        logic [15:0] src;
        logic [15:0] dst;
    } verdict_t;

    // One row of the directed table; has_verdict marks rows whose
    // expected verdict is typed in and cross-checked with the predictor.
    typedef struct {
        logic        req;
        logic [7:0]  pbyte;
        logic        last;
        logic [4:0]  idx;
        logic [15:0] port;
        logic        vld;
        logic        has_verdict;
        verdict_t    verdict;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_packet_byte = '0;
    logic        s_last_byte = 1'b0;
    logic [4:0]  s_entry_index = '0;
    logic [15:0] s_entry_port = '0;
    logic        s_entry_valid = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_keep_packet;
    logic        m_headers_ok;
    logic [15:0] m_src_port;
    logic [15:0] m_dst_port;

    dns_port_packet_classifier #(.PORT_TABLE_DEPTH(TABLE_SLOTS)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: frame parse registers and the port table.
    int          frame_pos;
    logic [15:0] frame_kind;
    logic        frame_tagged;
    logic [3:0]  frame_ihl;
    logic        frame_frag;
    logic [7:0]  frame_proto;
    logic [15:0] frame_src;
    logic [15:0] frame_dst;
    logic        slot_on   [TABLE_SLOTS];
    logic [15:0] slot_port [TABLE_SLOTS];

    verdict_t pending_verdicts[$];
    int       error_count = 0;
    int       words_sent = 0;
    logic     hold_request = 1'b0;
    logic     frame_no_gaps = 1'b0;

    task automatic clear_frame();
        frame_pos = 0;
        frame_kind = '0;
        frame_tagged = 1'b0;
        frame_ihl = '0;
        frame_frag = 1'b0;
        frame_proto = '0;
        frame_src = '0;
        frame_dst = '0;
    endtask

    function automatic logic port_listed(logic [15:0] port);
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_on[i] && slot_port[i] == port) return 1'b1;
        return 1'b0;
    endfunction

    // Offset of the transport header, 0 when there is no usable IP header.
    function automatic int transport_start(int l3);
        if (frame_kind == KIND_IP4) return (frame_ihl < IHL_MIN) ? 0 : l3 + frame_ihl * 4;
        if (frame_kind == KIND_IP6) return l3 + IP6_LEN;
        return 0;
    endfunction

    // Advance the frame parse by one byte; return 1 with a verdict on the last byte.
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output logic done, output verdict_t v);
        int p, l3, t, len;
        logic ok;
        p = frame_pos;
        done = 1'b0;
        v = '{1'b0, 1'b0, 16'h0, 16'h0};
        if (p == 12) frame_kind[15:8] = b;
        else if (p == 13) frame_kind[7:0] = b;
        else begin
            if (p == 14) frame_tagged = (frame_kind == KIND_TAG_Q || frame_kind == KIND_TAG_AD);
            if (frame_tagged && p == 16) frame_kind[15:8] = b;
            else if (frame_tagged && p == 17) frame_kind[7:0] = b;
            else begin
                l3 = ETH_HDR_LEN + (frame_tagged ? TAG_LEN : 0);
                if (p >= l3) begin
                    if (frame_kind == KIND_IP4) begin
                        case (p - l3)
                            0: frame_ihl = b[3:0];
                            6: frame_frag = (b[4:0] != 0);
                            7: frame_frag = frame_frag || (b != 0);
                            9: frame_proto = b;
                            default: ;
                        endcase
                    end else if (frame_kind == KIND_IP6 && p - l3 == 6) begin
                        frame_proto = b;
                    end
                    t = transport_start(l3);
                    if (t != 0 && p >= t && p < t + 4) begin
                        case (p - t)
                            0: frame_src[15:8] = b;
                            1: frame_src[7:0] = b;
                            2: frame_dst[15:8] = b;
                            default: frame_dst[7:0] = b;
                        endcase
                    end
                end
            end
        end
        if (frame_pos < 255) frame_pos++;
        if (last) begin
            len = frame_pos;
            l3 = ETH_HDR_LEN + (frame_tagged ? TAG_LEN : 0);
            t = transport_start(l3);
            ok = 1'b0;
            if (len >= ETH_HDR_LEN) begin
                if (frame_kind == KIND_IP4)
                    ok = (len >= l3 + IP4_MIN_LEN) && frame_ihl >= IHL_MIN && !frame_frag;
                else if (frame_kind == KIND_IP6)
                    ok = (len >= l3 + IP6_LEN);
                if (ok) begin
                    if (frame_proto == PROTO_UDP) ok = (len >= t + UDP_LEN);
                    else if (frame_proto == PROTO_TCP) ok = (len >= t + TCP_LEN);
                    else ok = 1'b0;
                end
            end
            v.ok = ok;
            v.src = ok ? frame_src : 16'h0;
            v.dst = ok ? frame_dst : 16'h0;
            v.keep = ok && (port_listed(frame_src) || port_listed(frame_dst));
            done = 1'b1;
            clear_frame();
        end
    endtask

    // Offer one word and hold it until accepted. Table writes go out at any
    // time, also while earlier frames are still in the match chain.
    task automatic send_word(input logic req, input logic [7:0] b, input logic last,
                             input logic [4:0] idx, input logic [15:0] port,
                             input logic vld, output logic done, output verdict_t v);
        int gap;
        @(negedge aclk);
        gap = frame_no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type = req;
        s_packet_byte = b;
        s_last_byte = last;
        s_entry_index = idx;
        s_entry_port = port;
        s_entry_valid = vld;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        done = 1'b0;
        if (req == REQ_ENTRY) begin
            slot_port[idx] = port;
            slot_on[idx] = vld;
        end else begin
            parse_byte(b, last, done, v);
            if (done) pending_verdicts.push_back(v);
        end
    endtask

    task automatic send_entry(input logic [4:0] idx, input logic [15:0] port, input logic vld);
        logic done;
        verdict_t v;
        send_word(REQ_ENTRY, 8'($urandom), 1'($urandom), idx, port, vld, done, v);
    endtask

    function automatic logic [15:0] pick_port();
        int k;
        k = $urandom_range(0, TABLE_SLOTS - 1);
        if ($urandom_range(0, 1) == 0) return slot_port[k];
        return 16'($urandom);
    endfunction

    // Build a frame from header choices; cut_len > 0 truncates it.
    task automatic send_frame(input int tag, input logic [15:0] kind, input logic [3:0] ihl,
                              input logic [7:0] frag_hi, input logic [7:0] frag_lo,
                              input logic [7:0] proto, input logic [15:0] sport,
                              input logic [15:0] dport, input int payload, input int cut_len,
                              input logic sprinkle_writes);
        logic [7:0] fb[$];
        int n, hdr;
        logic done;
        verdict_t v;
        for (int i = 0; i < 12; i++) fb.push_back(8'($urandom));
        if (tag != TAG_NONE) begin
            fb.push_back(tag == TAG_Q ? KIND_TAG_Q[15:8] : KIND_TAG_AD[15:8]);
            fb.push_back(tag == TAG_Q ? KIND_TAG_Q[7:0] : KIND_TAG_AD[7:0]);
            fb.push_back(8'($urandom));
            fb.push_back(8'($urandom));
        end
        fb.push_back(kind[15:8]);
        fb.push_back(kind[7:0]);
        if (kind == KIND_IP6) begin
            for (int i = 0; i < IP6_LEN; i++)
                fb.push_back(i == 6 ? proto : 8'($urandom));
        end else begin
            hdr = (ihl < IHL_MIN) ? IP4_MIN_LEN : ihl * 4;
            for (int i = 0; i < hdr; i++) begin
                case (i)
                    0: fb.push_back({4'($urandom), ihl});
                    6: fb.push_back(frag_hi);
                    7: fb.push_back(frag_lo);
                    9: fb.push_back(proto);
                    default: fb.push_back(8'($urandom));
                endcase
            end
        end
        fb.push_back(sport[15:8]);
        fb.push_back(sport[7:0]);
        fb.push_back(dport[15:8]);
        fb.push_back(dport[7:0]);
        repeat ((proto == PROTO_TCP ? TCP_LEN : UDP_LEN) - 4 + payload)
            fb.push_back(8'($urandom));
        n = (cut_len > 0 && cut_len < fb.size()) ? cut_len : fb.size();
        for (int i = 0; i < n; i++) begin
            if (sprinkle_writes && $urandom_range(0, 19) == 0)
                send_entry(5'($urandom), pick_port(), 1'($urandom));
            send_word(REQ_BYTE, fb[i], i == n - 1, '0, '0, 1'b0, done, v);
        end
    endtask

    task automatic send_random_frame();
        int tag, sel, payload, cut;
        logic [15:0] kind;
        logic [3:0] ihl;
        logic [7:0] fhi, flo, proto;
        logic done;
        verdict_t v;
        frame_no_gaps = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            // noise: random bytes of random length
            cut = $urandom_range(1, 60);
            for (int i = 0; i < cut; i++)
                send_word(REQ_BYTE, 8'($urandom), i == cut - 1, '0, '0, 1'b0, done, v);
            frame_no_gaps = 1'b0;
            return;
        end
        tag = $urandom_range(0, 5) < 3 ? TAG_NONE : $urandom_range(TAG_Q, TAG_AD);
        sel = $urandom_range(0, 9);
        kind = sel < 5 ? KIND_IP4 : sel < 9 ? KIND_IP6 : 16'($urandom);
        ihl = $urandom_range(0, 3) != 0 ? IHL_MIN : 4'($urandom);
        fhi = $urandom_range(0, 5) != 0 ? {3'($urandom), 5'd0} : 8'($urandom);
        flo = $urandom_range(0, 5) != 0 ? 8'h00 : 8'($urandom);
        sel = $urandom_range(0, 9);
        proto = sel < 5 ? PROTO_UDP : sel < 9 ? PROTO_TCP : 8'($urandom);
        payload = $urandom_range(0, 29) == 0 ? $urandom_range(150, 260) : $urandom_range(0, 12);
        cut = $urandom_range(0, 4) == 0 ? $urandom_range(1, 80) : 0;
        send_frame(tag, kind, ihl, fhi, flo, proto, pick_port(), pick_port(),
                   payload, cut, 1'b1);
        frame_no_gaps = 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each result word with the oldest expected verdict.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result keep=%0d ok=%0d src=%h dst=%h", $time,
                         m_keep_packet, m_headers_ok, m_src_port, m_dst_port);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_keep_packet !== want.keep) begin
                    $display("%0t: keep_packet expected %0d actual %0d",
                             $time, want.keep, m_keep_packet);
                    error_count++;
                end
                if (m_headers_ok !== want.ok) begin
                    $display("%0t: headers_ok expected %0d actual %0d",
                             $time, want.ok, m_headers_ok);
                    error_count++;
                end
                if (m_src_port !== want.src) begin
                    $display("%0t: src_port expected %h actual %h", $time, want.src, m_src_port);
                    error_count++;
                end
                if (m_dst_port !== want.dst) begin
                    $display("%0t: dst_port expected %h actual %h", $time, want.dst, m_dst_port);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: stop on a long stretch with no word moving on either side.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_verdicts.size());
            $display("FAIL dns_port_packet_classifier");
            $finish;
        end
    end

    row_t directed_rows[$] = '{
        '{REQ_ENTRY, 8'h00, 1'b0, 5'd0,  16'h0000, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{REQ_ENTRY, 8'hFF, 1'b1, 5'd31, 16'hFFFF, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{REQ_ENTRY, 8'h00, 1'b0, 5'd5,  16'd53,   1'b1, 1'b0, '{0, 0, 0, 0}},
        '{REQ_ENTRY, 8'h00, 1'b0, 5'd6,  16'd443,  1'b1, 1'b0, '{0, 0, 0, 0}},
        '{REQ_ENTRY, 8'h00, 1'b0, 5'd7,  16'd1234, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{REQ_BYTE,  8'hFF, 1'b1, 5'd0,  16'h0000, 1'b0, 1'b1, '{0, 0, 0, 0}},
        '{REQ_BYTE,  8'h00, 1'b1, 5'd0,  16'h0000, 1'b0, 1'b1, '{0, 0, 0, 0}},
        '{REQ_BYTE,  8'hAA, 1'b0, 5'd0,  16'h0000, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{REQ_BYTE,  8'h55, 1'b1, 5'd0,  16'h0000, 1'b0, 1'b1, '{0, 0, 0, 0}}
    };

    initial begin
        logic done;
        verdict_t v;
        clear_frame();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_on[i] = 1'b0;
            slot_port[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: table extremes and tiny frames, typed verdicts cross-checked.
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].req, directed_rows[i].pbyte, directed_rows[i].last,
                      directed_rows[i].idx, directed_rows[i].port, directed_rows[i].vld,
                      done, v);
            if (directed_rows[i].has_verdict &&
                (v.keep !== directed_rows[i].verdict.keep ||
                 v.ok !== directed_rows[i].verdict.ok ||
                 v.src !== directed_rows[i].verdict.src ||
                 v.dst !== directed_rows[i].verdict.dst)) begin
                $display("%0t: row %0d verdict expected ok=%0d actual ok=%0d", $time, i,
                         directed_rows[i].verdict.ok, v.ok);
                error_count++;
            end
        end
        // Directed frames: plain UDP hit, tagged TCP, both tag kinds, bad IHL,
        // fragments, other EtherType and protocol, truncation, long frame.
        send_frame(TAG_NONE, KIND_IP4, 4'd5, 8'h00, 8'h00, PROTO_UDP, 16'd5000, 16'd53,
                   0, 0, 1'b0);
        send_frame(TAG_Q, KIND_IP6, 4'd5, 8'h00, 8'h00, PROTO_TCP, 16'd443, 16'd80,
                   0, 0, 1'b0);
        send_frame(TAG_AD, KIND_IP4, 4'd15, 8'h40, 8'h00, PROTO_TCP, 16'hFFFF, 16'h0000,
                   2, 0, 1'b0);
        send_frame(TAG_NONE, KIND_IP4, 4'd4, 8'h00, 8'h00, PROTO_UDP, 16'd53, 16'd53,
                   0, 0, 1'b0);
        send_frame(TAG_NONE, KIND_IP4, 4'd5, 8'h01, 8'h00, PROTO_UDP, 16'd53, 16'd53,
                   0, 0, 1'b0);
        send_frame(TAG_NONE, KIND_IP4, 4'd5, 8'h00, 8'h01, PROTO_UDP, 16'd53, 16'd53,
                   0, 0, 1'b0);
        send_frame(TAG_NONE, 16'h0806, 4'd5, 8'h00, 8'h00, PROTO_UDP, 16'd53, 16'd53,
                   0, 0, 1'b0);
        send_frame(TAG_NONE, KIND_IP6, 4'd5, 8'h00, 8'h00, 8'd1, 16'd53, 16'd53,
                   0, 0, 1'b0);
        send_frame(TAG_NONE, KIND_IP4, 4'd5, 8'h00, 8'h00, PROTO_UDP, 16'd53, 16'd53,
                   0, 41, 1'b0);
        send_frame(TAG_Q, KIND_IP4, 4'd5, 8'h00, 8'h00, PROTO_TCP, 16'd1, 16'd443,
                   0, 57, 1'b0);
        send_frame(TAG_NONE, KIND_IP6, 4'd5, 8'h00, 8'h00, PROTO_UDP, 16'd7, 16'd53,
                   200, 0, 1'b0);

        // Long hold-off on the result side while one-byte frames pile up.
        hold_request = 1'b1;
        frame_no_gaps = 1'b1;
        repeat (80) send_word(REQ_BYTE, 8'($urandom), 1'b1, '0, '0, 1'b0, done, v);
        frame_no_gaps = 1'b0;

        // Remove the extreme entries once so the table also shrinks.
        send_entry(5'd0, 16'h0000, 1'b0);
        send_entry(5'd31, 16'hFFFF, 1'b0);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) send_random_frame();

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) $display("PASS dns_port_packet_classifier");
        else $display("FAIL dns_port_packet_classifier");
        $finish;
    end
endmodule
`default_nettype wire
